// ===== design/blos_pkg.sv =====
// Shared types and constants for the line-of-sight block.
`default_nettype none
package blos_pkg;

  // Fixed field widths of the item and register formats.
  localparam int COORD_W = 8;
  localparam int ELEV_W  = 16;
  localparam int WIDTH_W = 9;
  // map_width * row + col never exceeds 511 * 255 + 255, which fits in 17 bits.
  localparam int SUM_W   = 17;
  // Bresenham error term and its doubled value.
  localparam int ERR_W   = 12;
  localparam int E2_W    = 13;

  // Item operation codes.
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // Configuration port: one register, selected by paddr[2].
  localparam int  APB_ADDR_W = 3;
  localparam int  APB_DATA_W = 32;
  localparam logic REG_MAP_WIDTH = 1'b0;
  localparam logic [WIDTH_W-1:0] MAP_WIDTH_RESET = 9'd256;

  // Commands from the sequencer to the address reduction unit.
  typedef struct packed {
    logic load;
    logic step;
  } red_ctrl_t;

endpackage
`default_nettype wire

// ===== design/blos_if.sv =====
// Valid/ready channel interfaces for query items and visibility results.
`default_nettype none
interface blos_item_if;
  import blos_pkg::*;
  logic                     valid;
  logic                     ready;
  logic                     op;
  logic [COORD_W-1:0]       src_row;
  logic [COORD_W-1:0]       src_col;
  logic signed [ELEV_W-1:0] cell_elevation;
  logic [COORD_W-1:0]       dst_row;
  logic [COORD_W-1:0]       dst_col;

  modport source(output valid, op, src_row, src_col, cell_elevation, dst_row, dst_col,
                 input ready);
  modport sink(input valid, op, src_row, src_col, cell_elevation, dst_row, dst_col,
               output ready);
endinterface

interface blos_result_if;
  logic valid;
  logic ready;
  logic visible;

  modport source(output valid, visible, input ready);
  modport sink(input valid, visible, output ready);
endinterface
`default_nettype wire

// ===== design/blos_ram.sv =====
// Generic single-port RAM with registered read data.
`default_nettype none
module blos_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 65536
) (
  input  wire logic                                      clk,
  input  wire logic                                      en,
  input  wire logic                                      we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
  input  wire logic [WIDTH-1:0]                          wdata,
  output logic      [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule
`default_nettype wire

// ===== design/blos_modred.sv =====
// Cell address unit: forms map_width*row+col and reduces it modulo the store depth.
`default_nettype none
module blos_modred #(
  parameter int MAP_SIDE = 256
) (
  input  wire logic                                  clk,
  input  wire blos_pkg::red_ctrl_t                   ctrl,
  input  wire logic [blos_pkg::WIDTH_W-1:0]          map_width,
  input  wire logic [blos_pkg::COORD_W-1:0]          row,
  input  wire logic [blos_pkg::COORD_W-1:0]          col,
  output logic [$clog2(MAP_SIDE*MAP_SIDE)-1:0]       addr,
  output logic                                       done
);
  import blos_pkg::*;

  localparam int DEPTH = MAP_SIDE * MAP_SIDE;
  localparam int AW    = $clog2(DEPTH);
  localparam int RW    = ((SUM_W > AW) ? SUM_W : AW) + 1;
  // Number of restoring subtract steps that bring any raw sum below DEPTH.
  localparam int QBITS = (SUM_W >= AW) ? (SUM_W - AW + 1) : 0;
  localparam int KW    = (QBITS > 1) ? $clog2(QBITS) : 1;
  localparam logic [KW-1:0] K_INIT = KW'((QBITS > 0) ? (QBITS - 1) : 0);
  localparam logic [RW-1:0] DEPTH_R = RW'(DEPTH);

  logic [RW-1:0] rem;
  logic [KW-1:0] k;
  logic [SUM_W-1:0] raw;
  logic [RW-1:0] shifted;

  assign raw     = SUM_W'(map_width) * SUM_W'(row) + SUM_W'(col);
  assign shifted = DEPTH_R << k;
  assign done    = rem < DEPTH_R;
  assign addr    = rem[AW-1:0];

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      rem <= RW'(raw);
      k   <= K_INIT;
    end else if (ctrl.step) begin
      if (rem >= shifted) begin
        rem <= rem - shifted;
      end
      k <= k - KW'(1);
    end
  end

endmodule
`default_nettype wire

// ===== design/bresenham_line_of_sight_top.sv =====
// Top level of the line-of-sight block: sequencer, map store and configuration port.
//
// The block holds an elevation map of MAP_SIDE*MAP_SIDE signed 16-bit cells in a
// single-port RAM, addressed as (map_width*row + col) modulo the store depth. A write
// transaction (op 0) stores one cell and produces no result. A query transaction
// (op 1) walks the Bresenham line from source to target, one cell at a time, and
// produces one result: visible is 0 as soon as a cell on the line, target included,
// is strictly higher than the source cell, and 1 otherwise. Every queried cell passes the
// sequencer states S_ADDR (form the address), S_RED (reduce it, then read the RAM) and
// S_CMP (compare and step); S_RED also holds for the subtract steps of the shared
// address reduction unit when the raw address reaches past the end of the store. The
// input is not ready while an item is being worked on. A finished result sits in an
// output register until taken, and the next item is accepted meanwhile. The map_width
// register (reset 256) is written over the APB port at byte address 0 and should only
// be changed while the block is idle. Cells must be written before a query reads them;
// the store has no reset.
`default_nettype none
module bresenham_line_of_sight_top #(
  parameter int MAP_SIDE = 256
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  blos_item_if.sink                            item,
  blos_result_if.source                        result,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [blos_pkg::APB_ADDR_W-1:0] paddr,
  input  wire logic [blos_pkg::APB_DATA_W-1:0] pwdata,
  output logic      [blos_pkg::APB_DATA_W-1:0] prdata,
  output logic                                 pready
);
  import blos_pkg::*;

  localparam int DEPTH = MAP_SIDE * MAP_SIDE;
  localparam int AW    = $clog2(DEPTH);

  typedef enum logic [1:0] {
    S_IDLE,
    S_ADDR,
    S_RED,
    S_CMP
  } state_t;

  state_t state;

  // Configuration register.
  logic [WIDTH_W-1:0] map_width;

  // Latched item and walk state.
  logic                     op_q;
  logic signed [ELEV_W-1:0] elev_q;
  logic [COORD_W-1:0]       cur_row;
  logic [COORD_W-1:0]       cur_col;
  logic [COORD_W-1:0]       dst_row_q;
  logic [COORD_W-1:0]       dst_col_q;
  logic [COORD_W-1:0]       dr;
  logic signed [ERR_W-1:0]  dc;
  logic                     row_down;
  logic                     col_down;
  logic signed [ERR_W-1:0]  err;
  logic                     first;
  logic signed [ELEV_W-1:0] base;

  // Result register.
  logic res_valid;
  logic res_visible;

  // Address unit and RAM signals.
  red_ctrl_t        red_ctrl;
  logic [AW-1:0]    cell_addr;
  logic             red_done;
  logic             ram_en;
  logic [ELEV_W-1:0] ram_rdata;

  // Combinational step values.
  logic [COORD_W-1:0]       row_diff;
  logic [COORD_W-1:0]       col_diff;
  logic signed [ERR_W-1:0]  dr_start;
  logic signed [ERR_W-1:0]  dc_start;
  logic signed [ELEV_W-1:0] cell_val;
  logic signed [ELEV_W-1:0] ref_val;
  logic                     blocked;
  logic                     at_target;
  logic                     res_free;
  logic                     res_done;
  logic signed [E2_W-1:0]   e2;
  logic                     step_row;
  logic                     step_col;
  logic signed [ERR_W-1:0]  err_next;

  assign item.ready    = (state == S_IDLE);
  assign result.valid  = res_valid;
  assign result.visible = res_visible;

  // APB register access; pready is tied high, so every access is zero-wait.
  assign pready = 1'b1;
  always_comb begin
    prdata = '0;
    if (paddr[APB_ADDR_W-1] == REG_MAP_WIDTH) begin
      prdata = APB_DATA_W'(map_width);
    end
  end

  // Absolute coordinate distances of the incoming query.
  assign row_diff = (item.dst_row > item.src_row) ? (item.dst_row - item.src_row)
                                                  : (item.src_row - item.dst_row);
  assign col_diff = (item.dst_col > item.src_col) ? (item.dst_col - item.src_col)
                                                  : (item.src_col - item.dst_col);
  assign dr_start = ERR_W'(row_diff);
  assign dc_start = -ERR_W'(col_diff);

  // The first cell read is the source cell and becomes the reference height.
  assign cell_val  = ram_rdata;
  assign ref_val   = first ? cell_val : base;
  assign blocked   = cell_val > ref_val;
  assign at_target = (cur_row == dst_row_q) && (cur_col == dst_col_q);
  assign res_free  = !res_valid || result.ready;
  assign res_done  = (state == S_CMP) && (blocked || at_target) && res_free;

  // Bresenham error update, both tests on the error before this step.
  assign e2       = E2_W'(err) <<< 1;
  assign step_row = e2 >= E2_W'(dc);
  assign step_col = e2 <= $signed(E2_W'(dr));
  assign err_next = err + (step_row ? dc : ERR_W'(0)) + (step_col ? ERR_W'(dr) : ERR_W'(0));

  // The address unit is loaded once per cell and then stepped until in range.
  always_comb begin
    red_ctrl.load = (state == S_ADDR);
    red_ctrl.step = (state == S_RED) && !red_done;
  end

  assign ram_en = (state == S_RED) && red_done;

  blos_modred #(
    .MAP_SIDE(MAP_SIDE)
  ) u_modred (
    .clk       (clk),
    .ctrl      (red_ctrl),
    .map_width (map_width),
    .row       (cur_row),
    .col       (cur_col),
    .addr      (cell_addr),
    .done      (red_done)
  );

  blos_ram #(
    .WIDTH(ELEV_W),
    .DEPTH(DEPTH)
  ) u_store (
    .clk   (clk),
    .en    (ram_en),
    .we    (op_q == OP_WRITE),
    .addr  (cell_addr),
    .wdata (elev_q),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      res_valid <= 1'b0;
      map_width <= MAP_WIDTH_RESET;
    end else begin
      if (psel && penable && pwrite && pready && (paddr[APB_ADDR_W-1] == REG_MAP_WIDTH)) begin
        map_width <= pwdata[WIDTH_W-1:0];
      end

      // A new result may replace one that is taken in the same cycle.
      if (res_done) begin
        res_valid <= 1'b1;
      end else if (res_valid && result.ready) begin
        res_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (item.valid) begin
            op_q      <= item.op;
            elev_q    <= item.cell_elevation;
            cur_row   <= item.src_row;
            cur_col   <= item.src_col;
            dst_row_q <= item.dst_row;
            dst_col_q <= item.dst_col;
            dr        <= row_diff;
            dc        <= dc_start;
            row_down  <= item.src_row >= item.dst_row;
            col_down  <= item.src_col >= item.dst_col;
            err       <= dr_start + dc_start;
            first     <= 1'b1;
            state     <= S_ADDR;
          end
        end
        S_ADDR: begin
          state <= S_RED;
        end
        S_RED: begin
          if (red_done) begin
            state <= (op_q == OP_WRITE) ? S_IDLE : S_CMP;
          end
        end
        S_CMP: begin
          if (blocked || at_target) begin
            // Hold here with the read data until the result register is free.
            if (res_free) begin
              res_visible <= !blocked;
              state       <= S_IDLE;
            end
          end else begin
            base  <= ref_val;
            first <= 1'b0;
            err   <= err_next;
            if (step_row) begin
              cur_row <= row_down ? (cur_row - COORD_W'(1)) : (cur_row + COORD_W'(1));
            end
            if (step_col) begin
              cur_col <= col_down ? (cur_col - COORD_W'(1)) : (cur_col + COORD_W'(1));
            end
            state <= S_ADDR;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== design/blos_checker.sv =====
// Port-level checker for the line-of-sight block and its bind to the top level.
`default_nettype none
module blos_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic visible
);

  // Every accepted item keeps the input not ready while it is worked on.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready ##1 !in_ready)
    else $error("input ready too soon after an accepted transaction");

  // A new result appears only at the end of a busy period.
  a_result_after_work: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared while the block was idle");

  // A stalled result is held unchanged.
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(visible)))
    else $error("stalled result changed or was dropped");

  // Reset leaves the block idle with no result pending.
  a_reset_state: assert property (@(posedge clk)
    rst |=> (in_ready && !out_valid))
    else $error("block not idle after reset");

endmodule

bind bresenham_line_of_sight_top blos_checker u_blos_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (item.valid),
  .in_ready  (item.ready),
  .out_valid (result.valid),
  .out_ready (result.ready),
  .visible   (result.visible)
);
`default_nettype wire

// ===== bench/los_bench_pkg.sv =====
`timescale 1ns / 100ps
// Scoreboard for the line-of-sight bench: map copy, Bresenham walk and answer checking.
package los_bench_pkg;
  import blos_pkg::*;

  localparam int MAP_SIDE    = 256;
  localparam int STORE_DEPTH = MAP_SIDE * MAP_SIDE;

  // Cells of a walked line, each packed as {row, col}.
  typedef logic [2*COORD_W-1:0] cell_list_t[$];

  typedef struct {
    logic               visible;
    logic [COORD_W-1:0] src_row, src_col, dst_row, dst_col;
  } sight_answer_t;

  class sight_checker;
    logic signed [ELEV_W-1:0] elev_map [STORE_DEPTH];
    logic [WIDTH_W-1:0]       map_width;
    sight_answer_t            pending_answers[$];
    int                       failures;
    int                       answers_checked;

    function new();
      map_width       = MAP_WIDTH_RESET;
      failures        = 0;
      answers_checked = 0;
    endfunction

    function void set_width(logic [WIDTH_W-1:0] w);
      map_width = w;
    endfunction

    function int unsigned cell_addr(logic [COORD_W-1:0] row, logic [COORD_W-1:0] col);
      return (int'(map_width) * int'(row) + int'(col)) % STORE_DEPTH;
    endfunction

    // Cells of the Bresenham line from source to target, both ends included.
    function cell_list_t walk_line(logic [COORD_W-1:0] r0, logic [COORD_W-1:0] c0,
                                   logic [COORD_W-1:0] r1, logic [COORD_W-1:0] c1);
      cell_list_t cells;
      int r, c, rt, ct, d_r, d_c, s_r, s_c, err, e2;
      r   = int'(r0);
      c   = int'(c0);
      rt  = int'(r1);
      ct  = int'(c1);
      d_r = (rt > r) ? rt - r : r - rt;
      d_c = (ct > c) ? c - ct : ct - c;
      s_r = (r < rt) ? 1 : -1;
      s_c = (c < ct) ? 1 : -1;
      err = d_r + d_c;
      forever begin
        cells.push_back({r[COORD_W-1:0], c[COORD_W-1:0]});
        if (r == rt && c == ct) break;
        e2 = err * 2;
        if (e2 >= d_c) begin
          err += d_c;
          r   += s_r;
        end
        if (e2 <= d_r) begin
          err += d_r;
          c   += s_c;
        end
      end
      return cells;
    endfunction

    function logic predict_visible(logic [COORD_W-1:0] sr, logic [COORD_W-1:0] sc,
                                   logic [COORD_W-1:0] dr, logic [COORD_W-1:0] dc);
      cell_list_t               cells;
      logic signed [ELEV_W-1:0] base;
      logic                     vis;
      cells = walk_line(sr, sc, dr, dc);
      base  = elev_map[cell_addr(sr, sc)];
      vis   = 1'b1;
      foreach (cells[i]) begin
        if (elev_map[cell_addr(cells[i][2*COORD_W-1:COORD_W], cells[i][COORD_W-1:0])] > base)
          vis = 1'b0;
      end
      return vis;
    endfunction

    function void flag(string msg);
      failures++;
      if (failures <= 10) $display("MISMATCH: %s", msg);
    endfunction

    function void note_item(logic op, logic [COORD_W-1:0] sr, logic [COORD_W-1:0] sc,
                            logic signed [ELEV_W-1:0] elev,
                            logic [COORD_W-1:0] dr, logic [COORD_W-1:0] dc);
      sight_answer_t a;
      if (op == OP_WRITE) begin
        elev_map[cell_addr(sr, sc)] = elev;
      end else begin
        a.visible = predict_visible(sr, sc, dr, dc);
        a.src_row = sr;
        a.src_col = sc;
        a.dst_row = dr;
        a.dst_col = dc;
        pending_answers.push_back(a);
      end
    endfunction

    function void check_result(logic visible);
      sight_answer_t a;
      if (pending_answers.size() == 0) begin
        flag($sformatf("result visible=%0d arrived with no query outstanding", visible));
        return;
      end
      a = pending_answers.pop_front();
      answers_checked++;
      if (visible !== a.visible)
        flag($sformatf("query (%0d,%0d)->(%0d,%0d): expected visible=%0d, got %0d",
                       a.src_row, a.src_col, a.dst_row, a.dst_col, a.visible, visible));
    endfunction

    function int pending();
      return pending_answers.size();
    endfunction
  endclass

endpackage

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps
// Top-level bench for the line-of-sight block: stimulus, APB programming and result checking.
module testbench;
  import blos_pkg::*;
  import los_bench_pkg::*;

  // Slowest correct run: about 1300 items, each a full 256-cell line with the longest address
  // reduction on every cell plus the longest gaps on both sides. The limit is a few times
  // the length of that run, so it only trips when the block hangs.
  localparam int CYCLE_LIMIT  = 6_000_000;
  // A write transaction can still be in flight after the last answer; this covers it.
  localparam int DRAIN_CYCLES = 40;
  // Long stretch with the result side held off, so the block fills up and stalls its input.
  localparam int HOLD_CYCLES  = 3000;
  localparam int RANDOM_ITEMS = 1080;
  localparam int N_PHASES     = 6;
  localparam logic [APB_ADDR_W-1:0] MAP_WIDTH_ADDR = {REG_MAP_WIDTH, 2'b00};

  logic                  clk;
  logic                  rst;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  blos_item_if   item ();
  blos_result_if result ();

  bresenham_line_of_sight_top #(.MAP_SIDE(MAP_SIDE)) dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item),
    .result (result),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  sight_checker sight = new();

  // Cells the stimulus has already written, by store address. A query is only sent once
  // every cell on its line is marked here, so no query ever reads an unwritten cell.
  bit   written [STORE_DEPTH];
  int   items_sent;
  // When set, the sender offers items back to back with no idle cycles.
  logic no_gaps;
  logic [WIDTH_W-1:0] phase_widths [N_PHASES];

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin : timeout_watch
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("testbench NOT OK");
    $finish;
  end

  // Every transaction on either channel is seen here, at the rising edge. Answers are
  // checked before a new query is noted, although a query can never be answered in the
  // same cycle in which it is accepted.
  always @(posedge clk) begin
    if (!rst) begin
      if (result.valid && result.ready) sight.check_result(result.visible);
      if (item.valid && item.ready)
        sight.note_item(item.op, item.src_row, item.src_col, item.cell_elevation,
                        item.dst_row, item.dst_col);
    end
  end

  // Mostly no gap or a short one, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 4);
    return $urandom_range(15, 60);
  endfunction

  // Elevations sit mostly in a narrow band so that both answers come up often; the
  // extremes and fully random values are mixed in.
  function automatic logic signed [ELEV_W-1:0] pick_elevation();
    int r, v;
    r = $urandom_range(0, 9);
    if (r == 9) return ELEV_W'($urandom);
    if (r == 8) return ($urandom_range(0, 1) == 1) ? 16'sh7fff : 16'sh8000;
    v = int'($urandom_range(0, 6)) - 3;
    return v[ELEV_W-1:0];
  endfunction

  // A coordinate near a cluster center, clipped to the map.
  function automatic logic [COORD_W-1:0] around(int ctr, int rad);
    int v;
    v = ctr + int'($urandom_range(0, 2 * rad)) - rad;
    if (v < 0) v = 0;
    if (v > MAP_SIDE - 1) v = MAP_SIDE - 1;
    return v[COORD_W-1:0];
  endfunction

  // Lowers valid for the idle stretch given by n. Each change lands on its own falling edge.
  task automatic idle_item(int n);
    if (n > 0) begin
      @(negedge clk);
      item.valid <= 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  // Offers one item and returns right after the edge at which it was accepted. Valid is
  // left high; the next offer or the next idle stretch sets it at the following edge.
  task automatic send_item(logic op, logic [COORD_W-1:0] sr, logic [COORD_W-1:0] sc,
                           logic signed [ELEV_W-1:0] elev,
                           logic [COORD_W-1:0] dr, logic [COORD_W-1:0] dc);
    @(negedge clk);
    item.op             <= op;
    item.src_row        <= sr;
    item.src_col        <= sc;
    item.cell_elevation <= elev;
    item.dst_row        <= dr;
    item.dst_col        <= dc;
    item.valid          <= 1'b1;
    do @(posedge clk); while (!item.ready);
    items_sent++;
  endtask

  task automatic paced_send(logic op, logic [COORD_W-1:0] sr, logic [COORD_W-1:0] sc,
                            logic signed [ELEV_W-1:0] elev,
                            logic [COORD_W-1:0] dr, logic [COORD_W-1:0] dc);
    idle_item(no_gaps ? 0 : pick_gap());
    send_item(op, sr, sc, elev, dr, dc);
  endtask

  // Write transaction for one cell. The target fields are don't-care and get noise.
  task automatic put_cell(logic [COORD_W-1:0] r, logic [COORD_W-1:0] c,
                          logic signed [ELEV_W-1:0] elev);
    written[sight.cell_addr(r, c)] = 1'b1;
    paced_send(OP_WRITE, r, c, elev, COORD_W'($urandom), COORD_W'($urandom));
  endtask

  // Query transaction. Any cell on the line that was never written is written first,
  // which keeps every query inside the contract.
  task automatic ask_sight(logic [COORD_W-1:0] sr, logic [COORD_W-1:0] sc,
                           logic [COORD_W-1:0] dr, logic [COORD_W-1:0] dc);
    cell_list_t         cells;
    logic [COORD_W-1:0] r, c;
    cells = sight.walk_line(sr, sc, dr, dc);
    foreach (cells[i]) begin
      r = cells[i][2*COORD_W-1:COORD_W];
      c = cells[i][COORD_W-1:0];
      if (!written[sight.cell_addr(r, c)]) put_cell(r, c, pick_elevation());
    end
    paced_send(OP_QUERY, sr, sc, pick_elevation(), dr, dc);
  endtask

  // One APB transfer: setup cycle, then access cycle until pready.
  task automatic apb_access(logic wr, logic [APB_DATA_W-1:0] wdata,
                            output logic [APB_DATA_W-1:0] rdata);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= MAP_WIDTH_ADDR;
    pwdata  <= wdata;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic check_width_reg(logic [WIDTH_W-1:0] w);
    logic [APB_DATA_W-1:0] rd;
    apb_access(1'b0, '0, rd);
    if (rd !== APB_DATA_W'(w))
      sight.flag($sformatf("map_width read back: expected %0d, got %0d", w, rd));
  endtask

  // Called only while the block is idle; the predictor switches at the same moment.
  task automatic program_width(logic [WIDTH_W-1:0] w);
    logic [APB_DATA_W-1:0] rd;
    apb_access(1'b1, APB_DATA_W'(w), rd);
    sight.set_width(w);
    check_width_reg(w);
  endtask

  // Drops valid, waits for every outstanding answer, then lets a trailing write finish.
  task automatic drain();
    @(negedge clk);
    item.valid <= 1'b0;
    while (sight.pending() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Random traffic in clusters: each cluster picks a center and a radius, so most
  // queries are short lines over cells that are rewritten now and then. A few writes go
  // anywhere on the map, and at most one long line per phase crosses it.
  task automatic random_phase(int quota);
    int stop, r, ctr_r, ctr_c, rad, left;
    bit long_done;
    stop      = items_sent + quota;
    left      = 0;
    long_done = 0;
    ctr_r     = 0;
    ctr_c     = 0;
    rad       = 1;
    while (items_sent < stop) begin
      if (left == 0) begin
        left = $urandom_range(10, 30);
        r = $urandom_range(0, 9);
        if (r < 2) begin
          // Clusters at the corners keep the coordinate extremes busy.
          ctr_r = ($urandom_range(0, 1) == 1) ? MAP_SIDE - 1 : 0;
          ctr_c = ($urandom_range(0, 1) == 1) ? MAP_SIDE - 1 : 0;
        end else begin
          ctr_r = $urandom_range(0, MAP_SIDE - 1);
          ctr_c = $urandom_range(0, MAP_SIDE - 1);
        end
        rad     = ($urandom_range(0, 3) == 0) ? 12 : $urandom_range(1, 5);
        no_gaps = ($urandom_range(0, 3) == 0);
      end
      left--;
      r = $urandom_range(0, 199);
      if (r < 60) begin
        put_cell(around(ctr_r, rad), around(ctr_c, rad), pick_elevation());
      end else if (r < 66) begin
        put_cell(COORD_W'($urandom), COORD_W'($urandom), pick_elevation());
      end else if (r < 68 && !long_done) begin
        long_done = 1;
        ask_sight(COORD_W'($urandom), COORD_W'($urandom),
                  COORD_W'($urandom), COORD_W'($urandom));
      end else begin
        ask_sight(around(ctr_r, rad), around(ctr_c, rad),
                  around(ctr_r, rad), around(ctr_c, rad));
      end
    end
    no_gaps = 0;
  endtask

  // The result side: bursts of ready with random gaps between them, and once, after
  // enough answers have been taken, a long hold-off while the sender keeps offering.
  initial begin : result_sink
    int  n;
    bit  held;
    result.ready = 1'b0;
    held         = 0;
    wait (rst === 1'b0);
    forever begin
      n = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 20);
      @(negedge clk);
      result.ready <= 1'b1;
      repeat (n - 1) @(negedge clk);
      n = pick_gap();
      if (n > 0) begin
        @(negedge clk);
        result.ready <= 1'b0;
        repeat (n - 1) @(negedge clk);
      end
      if (!held && sight.answers_checked >= 150) begin
        held = 1;
        @(negedge clk);
        result.ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end
    end
  end

  initial begin : stimulus
    logic [APB_DATA_W-1:0] rd;
    rst                 = 1'b1;
    psel                = 1'b0;
    penable             = 1'b0;
    pwrite              = 1'b0;
    paddr               = '0;
    pwdata              = '0;
    item.valid          = 1'b0;
    item.op             = OP_WRITE;
    item.src_row        = '0;
    item.src_col        = '0;
    item.cell_elevation = '0;
    item.dst_row        = '0;
    item.dst_col        = '0;
    no_gaps             = 0;
    items_sent          = 0;
    // Widths for the later phases: zero, the smallest, the largest field value, one
    // below the reset value, a random one and the reset value written back.
    phase_widths = '{9'd0, 9'd1, 9'd511, 9'd255, 9'd256, 9'd256};
    phase_widths[4] = WIDTH_W'($urandom_range(2, 510));

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // The register must come out of reset at its documented value.
    check_width_reg(MAP_WIDTH_RESET);

    // Directed part, at the reset width.
    // A query whose source equals its target reads only the source cell.
    put_cell(8'd0, 8'd0, 16'sd0);
    ask_sight(8'd0, 8'd0, 8'd0, 8'd0);
    // Cells equal to the source height do not block; the lowest elevation in between.
    put_cell(8'd0, 8'd1, 16'sh8000);
    put_cell(8'd0, 8'd2, 16'sd0);
    ask_sight(8'd0, 8'd0, 8'd0, 8'd2);
    // Only the target is higher, and the target counts.
    put_cell(8'd0, 8'd3, 16'sd1);
    ask_sight(8'd0, 8'd0, 8'd0, 8'd3);
    // Diagonal at the far corner with the highest and lowest elevations.
    put_cell(8'd255, 8'd255, 16'sh7fff);
    put_cell(8'd254, 8'd254, 16'sh8000);
    put_cell(8'd253, 8'd253, 16'sh7fff);
    ask_sight(8'd255, 8'd255, 8'd253, 8'd253);
    ask_sight(8'd254, 8'd254, 8'd255, 8'd255);
    // Negative elevations, looking down and looking up.
    put_cell(8'd255, 8'd0, -16'sd1);
    put_cell(8'd254, 8'd0, -16'sd2);
    ask_sight(8'd255, 8'd0, 8'd254, 8'd0);
    ask_sight(8'd254, 8'd0, 8'd255, 8'd0);
    // Lines that step down in one coordinate and up in the other.
    ask_sight(8'd0, 8'd255, 8'd3, 8'd253);
    ask_sight(8'd255, 8'd128, 8'd250, 8'd130);

    random_phase(RANDOM_ITEMS / (N_PHASES + 1));

    // The store keeps its contents across width changes, and the written marks are by
    // address, so they stay valid too. Row 255 at the largest width wraps the address.
    for (int p = 0; p < N_PHASES; p++) begin
      drain();
      program_width(phase_widths[p]);
      ask_sight(8'd255, 8'd255, 8'd255, 8'd251);
      ask_sight(8'd0, 8'd0, 8'd3, 8'd1);
      random_phase(RANDOM_ITEMS / (N_PHASES + 1));
    end

    drain();
    if (sight.failures == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/blos_pkg.sv
design/blos_if.sv
design/blos_ram.sv
design/blos_modred.sv
design/bresenham_line_of_sight_top.sv
design/blos_checker.sv
bench/los_bench_pkg.sv
bench/testbench.sv
